// ----- hw/rtl/yrc_pkg.sv -----
// Package for the YUV/RGB color converter: payload types, register map, coefficients.
`default_nettype none

package yrc_pkg;

  // Chroma is shared by a group of this many consecutive pixels
  localparam int CHROMA_GROUP = 4;
  localparam int PHASE_W      = $clog2(CHROMA_GROUP);
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(CHROMA_GROUP - 1);

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_DIRECTION = 1'b0;   // register index, taken from paddr[2]

  // Direction codes
  localparam logic DIR_YUV2RGB = 1'b0;
  localparam logic DIR_RGB2YUV = 1'b1;

  // Internal arithmetic width: covers every sum of products with margin
  localparam int ACC_W = 20;

  // YUV to RGB coefficients
  localparam logic signed [ACC_W-1:0] K_Y    = 20'sd298;
  localparam logic signed [ACC_W-1:0] K_RV   = 20'sd409;
  localparam logic signed [ACC_W-1:0] K_GU   = 20'sd100;
  localparam logic signed [ACC_W-1:0] K_GV   = 20'sd208;
  localparam logic signed [ACC_W-1:0] K_BU   = 20'sd516;

  // RGB to YUV coefficients
  localparam logic signed [ACC_W-1:0] K_YR   = 20'sd66;
  localparam logic signed [ACC_W-1:0] K_YG   = 20'sd129;
  localparam logic signed [ACC_W-1:0] K_YB   = 20'sd25;
  localparam logic signed [ACC_W-1:0] K_UR   = 20'sd38;
  localparam logic signed [ACC_W-1:0] K_UG   = 20'sd74;
  localparam logic signed [ACC_W-1:0] K_UVB  = 20'sd112;
  localparam logic signed [ACC_W-1:0] K_VG   = 20'sd94;
  localparam logic signed [ACC_W-1:0] K_VB   = 20'sd18;

  localparam logic signed [ACC_W-1:0] ROUND  = 20'sd128;
  localparam logic signed [ACC_W-1:0] OFS_16 = 20'sd16;
  localparam logic signed [ACC_W-1:0] OFS_128 = 20'sd128;

  localparam logic [7:0] Y_MIN = 8'd16;
  localparam logic [7:0] Y_MAX = 8'd235;

  typedef struct packed {
    logic [7:0] comp_first;
    logic [7:0] comp_second;
    logic [7:0] comp_third;
    logic       last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [7:0] res_first;
    logic [7:0] res_second;
    logic [7:0] res_third;
    logic       chroma_valid;
  } result_t;

  // Saturate a signed value to 0..255
  function automatic logic [7:0] clamp_u8(input logic signed [ACC_W-1:0] x);
    logic [7:0] r;
    if (x < 0) begin
      r = 8'd0;
    end else if (x > 20'sd255) begin
      r = 8'd255;
    end else begin
      r = x[7:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/yuv_rgb_color_convert.sv -----
// Top level of the BT.601 YUV/RGB pixel color converter.
`default_nettype none

// Converts one pixel per clock between YCbCr and RGB (BT.601 integer
// coefficients), direction chosen by the direction register at byte address 0
// (0: YUV to RGB with clamping, 1: RGB to YUV with U/V given on the first
// pixel of each group of four, chroma_valid low and U/V zero otherwise). A
// request passes an input register and then a result register before its
// result is valid; a new pixel is taken every cycle as long as the result
// side does not stall. The group phase advances on every pixel and restarts
// after a pixel marked last_pixel. Change direction only while no pixel is
// in flight.
module yuv_rgb_color_convert (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // pixel input
  input  wire logic                                pixel_valid,
  output logic                                     pixel_stall,
  input  wire yrc_pkg::pixel_t                     pixel,
  // result output
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output yrc_pkg::result_t                         result,
  // configuration
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [yrc_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire logic [yrc_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [yrc_pkg::APB_DATA_W-1:0]           prdata,
  output logic                                     pready
);

  logic                             direction;
  logic [yrc_pkg::PHASE_W-1:0]      group_phase;
  logic [yrc_pkg::PHASE_W-1:0]      group_phase_next;

  logic                             s1_valid;
  yrc_pkg::pixel_t                  s1_pix;
  logic                             s1_dir;
  logic                             s1_first;

  logic                             s2_load;
  logic                             pix_accept;
  yrc_pkg::result_t                 result_next;

  logic signed [yrc_pkg::ACC_W-1:0] ca, cb, cc;
  logic signed [yrc_pkg::ACC_W-1:0] yy, uu, vv;
  logic signed [yrc_pkg::ACC_W-1:0] r_sum, g_sum, b_sum;
  logic signed [yrc_pkg::ACC_W-1:0] y_sum, u_sum, v_sum;
  logic signed [yrc_pkg::ACC_W-1:0] y_out, u_out, v_out;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= yrc_pkg::DIR_YUV2RGB;
    end else if (psel && penable && pwrite && pready && paddr[2] == yrc_pkg::REG_DIRECTION) begin
      direction <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == yrc_pkg::REG_DIRECTION) begin
      prdata[0] = direction;
    end
  end

  // Pipeline flow: result register loads when empty or drained
  assign s2_load     = !result_valid || !result_stall;
  assign pixel_stall = s1_valid && !s2_load;
  assign pix_accept  = pixel_valid && !pixel_stall;

  // Group phase tracks the position of the next pixel within its chroma group
  always_comb begin
    if (pixel.last_pixel || group_phase == yrc_pkg::PHASE_LAST) begin
      group_phase_next = '0;
    end else begin
      group_phase_next = group_phase + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_phase <= '0;
    end else if (pix_accept) begin
      group_phase <= group_phase_next;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_accept) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      s1_pix   <= pixel;
      s1_dir   <= direction;
      s1_first <= (group_phase == '0);
    end
  end

  // Conversion arithmetic
  assign ca = {12'b0, s1_pix.comp_first};
  assign cb = {12'b0, s1_pix.comp_second};
  assign cc = {12'b0, s1_pix.comp_third};

  // YUV to RGB
  assign yy    = yrc_pkg::K_Y * (ca - yrc_pkg::OFS_16);
  assign uu    = cb - yrc_pkg::OFS_128;
  assign vv    = cc - yrc_pkg::OFS_128;
  assign r_sum = yy + yrc_pkg::K_RV * vv + yrc_pkg::ROUND;
  assign g_sum = yy - yrc_pkg::K_GU * uu - yrc_pkg::K_GV * vv + yrc_pkg::ROUND;
  assign b_sum = yy + yrc_pkg::K_BU * uu + yrc_pkg::ROUND;

  // RGB to YUV
  assign y_sum = yrc_pkg::K_YR * ca + yrc_pkg::K_YG * cb + yrc_pkg::K_YB * cc
                 + yrc_pkg::ROUND;
  assign u_sum = yrc_pkg::K_UVB * cc - yrc_pkg::K_UR * ca - yrc_pkg::K_UG * cb
                 + yrc_pkg::ROUND;
  assign v_sum = yrc_pkg::K_UVB * ca - yrc_pkg::K_VG * cb - yrc_pkg::K_VB * cc
                 + yrc_pkg::ROUND;
  assign y_out = (y_sum >>> 8) + yrc_pkg::OFS_16;
  assign u_out = (u_sum >>> 8) + yrc_pkg::OFS_128;
  assign v_out = (v_sum >>> 8) + yrc_pkg::OFS_128;

  // Result selection
  always_comb begin
    if (s1_dir == yrc_pkg::DIR_YUV2RGB) begin
      result_next.res_first    = yrc_pkg::clamp_u8(r_sum >>> 8);
      result_next.res_second   = yrc_pkg::clamp_u8(g_sum >>> 8);
      result_next.res_third    = yrc_pkg::clamp_u8(b_sum >>> 8);
      result_next.chroma_valid = 1'b1;
    end else begin
      result_next.res_first = y_out[7:0];
      if (s1_first) begin
        result_next.res_second   = u_out[7:0];
        result_next.res_third    = v_out[7:0];
        result_next.chroma_valid = 1'b1;
      end else begin
        result_next.res_second   = 8'd0;
        result_next.res_third    = 8'd0;
        result_next.chroma_valid = 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s2_load) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/yrc_checker.sv -----
// Port-level checker for the YUV/RGB color converter, bound to the top level.
`default_nettype none

module yrc_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             result_valid,
  input wire logic             result_stall,
  input wire yrc_pkg::result_t result
);

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // Pixels without chroma carry zero U and V
  a_no_chroma_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.chroma_valid |->
      result.res_second == 8'd0 && result.res_third == 8'd0)
    else $error("chroma fields nonzero without chroma_valid");

  // Pixels without chroma are RGB to YUV results, so luma stays in video range
  a_luma_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.chroma_valid |->
      result.res_first >= yrc_pkg::Y_MIN && result.res_first <= yrc_pkg::Y_MAX)
    else $error("luma outside 16..235");

endmodule

bind yuv_rgb_color_convert yrc_checker u_yrc_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire

// ----- bench/tb_yuv_rgb_color_convert.sv -----
// Testbench for the BT.601 YUV/RGB pixel color converter.
`timescale 1ns / 1ps

import yrc_pkg::*;

// Predicts the converted pixel for each accepted request and checks results in order
class pixel_conv_tracker;
  logic        direction;
  int unsigned group_phase;
  result_t     conv_pending[$];
  int          errors;
  int          seen;

  function new();
    direction   = DIR_YUV2RGB;
    group_phase = 0;
    errors      = 0;
    seen        = 0;
  endfunction

  // Register write as the block takes it: only index 0 exists, only bit 0 kept
  function void write_reg(int unsigned idx, logic [APB_DATA_W-1:0] value);
    if (idx == REG_DIRECTION) begin
      direction = value[0];
    end
  endfunction

  function automatic logic [7:0] sat_byte(int x);
    if (x < 0) begin
      return 8'd0;
    end else if (x > 255) begin
      return 8'd255;
    end
    return 8'(x);
  endfunction

  function void note_pixel(pixel_t p);
    int      a, b, c, luma, cb, cr;
    result_t r;
    a = int'(p.comp_first);
    b = int'(p.comp_second);
    c = int'(p.comp_third);
    if (direction == DIR_YUV2RGB) begin
      luma = 298 * (a - 16);
      cb   = b - 128;
      cr   = c - 128;
      r.res_first    = sat_byte((luma + 409 * cr + 128) >>> 8);
      r.res_second   = sat_byte((luma - 100 * cb - 208 * cr + 128) >>> 8);
      r.res_third    = sat_byte((luma + 516 * cb + 128) >>> 8);
      r.chroma_valid = 1'b1;
    end else begin
      r.res_first = 8'(((66 * a + 129 * b + 25 * c + 128) >>> 8) + 16);
      // chroma only on the first pixel of a group
      if (group_phase == 0) begin
        r.res_second   = 8'(((-38 * a - 74 * b + 112 * c + 128) >>> 8) + 128);
        r.res_third    = 8'(((112 * a - 94 * b - 18 * c + 128) >>> 8) + 128);
        r.chroma_valid = 1'b1;
      end else begin
        r.res_second   = 8'd0;
        r.res_third    = 8'd0;
        r.chroma_valid = 1'b0;
      end
    end
    conv_pending.push_back(r);
    // phase restarts after a marked last pixel or at group end
    if (p.last_pixel || group_phase == CHROMA_GROUP - 1) begin
      group_phase = 0;
    end else begin
      group_phase = group_phase + 1;
    end
  endfunction

  task report_mismatch(string msg);
    errors++;
    $display("result %0d: %s", seen, msg);
  endtask

  task check_result(result_t r);
    result_t want;
    if (conv_pending.size() == 0) begin
      report_mismatch("result with no request outstanding");
    end else begin
      want = conv_pending.pop_front();
      if (r.res_first !== want.res_first)
        report_mismatch($sformatf("res_first got %0d want %0d", r.res_first, want.res_first));
      if (r.res_second !== want.res_second)
        report_mismatch($sformatf("res_second got %0d want %0d", r.res_second,
                                  want.res_second));
      if (r.res_third !== want.res_third)
        report_mismatch($sformatf("res_third got %0d want %0d", r.res_third, want.res_third));
      if (r.chroma_valid !== want.chroma_valid)
        report_mismatch($sformatf("chroma_valid got %0b want %0b", r.chroma_valid,
                                  want.chroma_valid));
    end
    seen++;
  endtask
endclass

module tb_yuv_rgb_color_convert;

  localparam logic [APB_ADDR_W-1:0] ADDR_DIRECTION = {REG_DIRECTION, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED    = {~REG_DIRECTION, 2'b00};
  localparam int                    CYCLE_LIMIT    = 300000;
  localparam int                    RAND_PHASES    = 8;
  localparam int                    PHASE_PIXELS   = 175;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  pixel_valid  = 1'b0;
  logic                  pixel_stall;
  pixel_t                pixel        = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  psel         = 1'b0;
  logic                  penable      = 1'b0;
  logic                  pwrite       = 1'b0;
  logic [APB_ADDR_W-1:0] paddr        = '0;
  logic [APB_DATA_W-1:0] pwdata       = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  stall_mode_t           stall_mode   = STALL_NONE;
  int                    stall_left   = 0;
  int                    stall_tick   = 0;
  int                    cycles       = 0;

  pixel_conv_tracker     sb = new();

  yuv_rgb_color_convert DUT (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #10 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result-side stall: picks a new random pattern whenever the current one runs out
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  result_stall <= 1'b0;
      STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
      default:     result_stall <= (stall_tick % 3 == 0);
    endcase
  end

  // Monitor both handshakes
  always @(posedge clk) begin
    if (!rst) begin
      if (pixel_valid && !pixel_stall) begin
        sb.note_pixel(pixel);
      end
      if (result_valid && !result_stall) begin
        sb.check_result(result);
      end
    end
  end

  // Present one request and hold it until taken
  task automatic push_pixel(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
                            input logic last);
    pixel_t p;
    p.comp_first  = a;
    p.comp_second = b;
    p.comp_third  = c;
    p.last_pixel  = last;
    pixel_valid <= 1'b1;
    pixel       <= p;
    do @(posedge clk); while (pixel_stall);
  endtask

  // Drain everything in flight, then let the pipeline settle
  task automatic wait_idle();
    pixel_valid <= 1'b0;
    // let the monitor note the last accepted request before the queue is polled
    @(posedge clk);
    while (sb.conv_pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(addr >> 2, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Component value biased toward the corners of the range
  function automatic logic [7:0] rand_comp();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd16;
      3:       return 8'd235;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Random stream in bursts; images end on a marked last pixel now and then
  task automatic run_stream(input int count, input bit gappy);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < count; k++) begin
        push_pixel(rand_comp(), rand_comp(), rand_comp(), $urandom_range(0, 11) == 0);
        sent++;
      end
      gap = (gappy && $urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        pixel_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    pixel_valid <= 1'b0;
  endtask

  initial begin
    logic dir;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: YUV to RGB corners and clamping
    apb_write(ADDR_DIRECTION, {31'd0, DIR_YUV2RGB});
    push_pixel(8'd0,   8'd0,   8'd0,   1'b0);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd16,  8'd128, 8'd128, 1'b0);
    push_pixel(8'd235, 8'd128, 8'd128, 1'b0);
    push_pixel(8'd255, 8'd0,   8'd255, 1'b0);
    push_pixel(8'd0,   8'd255, 8'd0,   1'b0);
    push_pixel(8'd128, 8'd255, 8'd0,   1'b1);
    push_pixel(8'd81,  8'd90,  8'd240, 1'b0);
    wait_idle();

    // Direction flip keeps the group phase; upper data bits are dropped
    apb_write(ADDR_DIRECTION, 32'hFFFF_FFFF);
    push_pixel(8'd0,   8'd0,   8'd0,   1'b0);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd255, 8'd0,   8'd0,   1'b0);
    push_pixel(8'd0,   8'd255, 8'd0,   1'b0);
    push_pixel(8'd0,   8'd0,   8'd255, 1'b0);
    push_pixel(8'd10,  8'd20,  8'd30,  1'b1);
    push_pixel(8'd255, 8'd255, 8'd0,   1'b0);
    push_pixel(8'd0,   8'd255, 8'd255, 1'b0);
    push_pixel(8'd255, 8'd0,   8'd255, 1'b1);
    push_pixel(8'd128, 8'd128, 8'd128, 1'b0);
    wait_idle();

    // Write to the unused address must be ignored
    apb_write(ADDR_UNUSED, 32'h0000_0000);
    push_pixel(8'd200, 8'd100, 8'd50,  1'b0);
    wait_idle();
    apb_write(ADDR_DIRECTION, 32'hFFFF_FFFE);
    push_pixel(8'd255, 8'd128, 8'd0,   1'b0);
    wait_idle();

    // Random phases, alternating direction
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      dir = (ph % 2 == 0) ? DIR_RGB2YUV : DIR_YUV2RGB;
      if ($urandom_range(0, 2) == 0) begin
        apb_write(ADDR_UNUSED, $urandom());
      end
      apb_write(ADDR_DIRECTION, {31'($urandom()), dir});
      run_stream(PHASE_PIXELS, ph != 3 && ph != 6);
      wait_idle();
    end

    // every accepted request must have produced its result
    if (sb.conv_pending.size() != 0) begin
      sb.report_mismatch("requests left without a result");
    end

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
